>>> sv/cco_pkg.sv
// Shared types and constants for the combination count and offset block.
// Used by the interfaces, cco_ctrl, cco_dp and combination_count_offsets_top.
package cco_pkg;

  localparam int IDX_W   = 32;            // list start / stop width
  localparam int K_W     = 7;             // choose count width
  localparam int CNT_W   = 63;            // count and offset width
  localparam int SIZE_W  = IDX_W + 2;     // signed list size
  localparam int HALF_W  = SIZE_W / 2;    // multiplier chunk of the factor
  localparam int PROD_W  = CNT_W + SIZE_W;
  localparam int J_W     = K_W + 1;
  localparam int BIT_W   = $clog2(PROD_W);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = K_W;

  localparam logic [K_W-1:0]   CHOOSE_RST = K_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WITH_REPLACEMENT = 1'd1;

  typedef struct packed {
    logic load;
    logic setup;
    logic classify;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic check;
    logic finish;
  } cco_cmd_t;

  typedef struct packed {
    logic trivial;    // count is 0 or 1 without iterating
    logic short_t;    // reduced k is one: count is the size
    logic div_last;   // final quotient bit this cycle
    logic overflow;   // quotient wider than 63 bits
    logic last_j;     // this iteration was the final one
    logic out_free;   // output register can take a word
  } cco_stat_t;

endpackage

>>> sv/cco_if.sv
// Valid/ready channels for list words in and count words out.
// Depends on cco_pkg for field widths.
interface cco_in_if;
  logic                        valid;
  logic                        ready;
  logic [cco_pkg::IDX_W-1:0]   list_start;
  logic [cco_pkg::IDX_W-1:0]   list_stop;
  logic                        last_list;

  modport source(output valid, list_start, list_stop, last_list, input ready);
  modport sink(input valid, list_start, list_stop, last_list, output ready);
endinterface

interface cco_out_if;
  logic                        valid;
  logic                        ready;
  logic [cco_pkg::CNT_W-1:0]   combo_count;
  logic [cco_pkg::CNT_W-1:0]   end_offset;
  logic                        is_total;
  logic                        overflowed;

  modport source(output valid, combo_count, end_offset, is_total, overflowed, input ready);
  modport sink(input valid, combo_count, end_offset, is_total, overflowed, output ready);
endinterface

>>> sv/cco_ctrl.sv
// Sequencer for the combination counter: setup, classify, then
// multiply / divide / check iterations. Depends on cco_pkg.
module cco_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cco_pkg::cco_stat_t   stat,
  output cco_pkg::cco_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_CLASSIFY, S_MUL_LO, S_MUL_HI, S_DIV, S_CHECK, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt    = (stat.trivial || stat.short_t) ? S_FINISH : S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = (stat.overflow || stat.last_j) ? S_FINISH : S_MUL_LO;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/cco_dp.sv
// Datapath: config registers, size and reduced k, 63x17 multiplier in two
// passes, bit-serial exact divider, running offset and output word register.
// Depends on cco_pkg and cco_out_if.
module cco_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cco_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cco_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  input  logic [cco_pkg::IDX_W-1:0]       list_start,
  input  logic [cco_pkg::IDX_W-1:0]       list_stop,
  input  logic                            last_list,
  input  cco_pkg::cco_cmd_t               cmd,
  output cco_pkg::cco_stat_t              stat,
  cco_out_if.source                       out_chan
);

  localparam int SW = cco_pkg::SIZE_W;
  localparam int HW = cco_pkg::HALF_W;
  localparam int PW = cco_pkg::PROD_W;
  localparam int CW = cco_pkg::CNT_W;
  localparam int KW = cco_pkg::K_W;
  localparam int JW = cco_pkg::J_W;

  // configuration
  logic [KW-1:0]  choose_r;
  logic           repl_r;

  // item state
  logic [cco_pkg::IDX_W-1:0] start_r, stop_r;
  logic                      last_r;
  logic [SW-1:0]             size_r;
  logic [KW-1:0]             t_r;
  logic [JW-1:0]             j_r;
  logic [CW-1:0]             cur_r;
  logic [PW-1:0]             prod_r;
  logic [KW-1:0]             rem_r;
  logic [cco_pkg::BIT_W-1:0] bit_cnt_r;
  logic                      sat_r;
  logic [CW-1:0]             running_r;

  // output word
  logic           out_valid_r;
  logic [CW-1:0]  count_out_r, offset_out_r;
  logic           total_out_r, ovf_out_r;

  // combinational
  logic [SW-1:0]      size_nxt, k_ext, size_less_k, factor;
  logic               size_lt_k, size_eq_k, use_sym;
  logic [KW-1:0]      t_nxt;
  logic [HW+CW-1:0]   p_lo, p_hi;
  logic [KW:0]        trial;
  logic               q_bit;
  logic [KW:0]        trial_sub;
  logic [CW:0]        sum;
  logic               off_sat;
  logic [CW-1:0]      end_nxt;

  assign k_ext       = SW'(choose_r);
  assign size_nxt    = {2'b00, stop_r} - {2'b00, start_r}
                     + (repl_r ? (k_ext - SW'(1)) : '0);
  assign size_lt_k   = $signed(size_r) < $signed(k_ext);
  assign size_eq_k   = size_r == k_ext;
  assign size_less_k = size_r - k_ext;
  // symmetry: take size - k when it is the smaller
  assign use_sym     = {k_ext[SW-2:0], 1'b0} > size_r;
  assign t_nxt       = use_sym ? size_less_k[KW-1:0] : choose_r;

  assign factor = size_r - SW'(j_r) + SW'(1);
  assign p_lo   = cur_r * factor[HW-1:0];
  assign p_hi   = cur_r * factor[SW-1:HW];

  assign trial     = {rem_r, prod_r[PW-1]};
  assign q_bit     = trial >= j_r;
  assign trial_sub = trial - j_r;

  assign sum     = {1'b0, running_r} + {1'b0, cur_r};
  assign off_sat = sum[CW];
  assign end_nxt = off_sat ? cco_pkg::CNT_MAX : sum[CW-1:0];

  always_comb begin
    stat          = '0;
    stat.trivial  = size_lt_k || size_eq_k || (choose_r == '0);
    stat.short_t  = t_nxt < KW'(2);
    stat.div_last = bit_cnt_r == cco_pkg::BIT_W'(PW - 1);
    stat.overflow = |prod_r[PW-1:CW];
    stat.last_j   = j_r >= {1'b0, t_r};
    stat.out_free = !out_valid_r || out_chan.ready;
  end

  // control state: config, running offset, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      choose_r    <= cco_pkg::CHOOSE_RST;
      repl_r      <= 1'b0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cco_pkg::CFG_CHOOSE_COUNT:     choose_r <= cfg_wdata;
          cco_pkg::CFG_WITH_REPLACEMENT: repl_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        running_r   <= last_r ? '0 : end_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= list_start;
      stop_r  <= list_stop;
      last_r  <= last_list;
    end
    if (cmd.setup) size_r <= size_nxt;
    if (cmd.classify) begin
      sat_r <= 1'b0;
      t_r   <= t_nxt;
      j_r   <= JW'(2);
      if (size_lt_k)                          cur_r <= '0;
      else if (size_eq_k || choose_r == '0)   cur_r <= CW'(1);
      else                                    cur_r <= CW'(size_r);
    end
    if (cmd.mul_lo) prod_r <= PW'(p_lo);
    if (cmd.mul_hi) begin
      prod_r    <= prod_r + {p_hi, {HW{1'b0}}};
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      // restoring division, quotient shifts in behind the dividend
      prod_r    <= {prod_r[PW-2:0], q_bit};
      rem_r     <= q_bit ? trial_sub[KW-1:0] : trial[KW-1:0];
      bit_cnt_r <= bit_cnt_r + 1'b1;
    end
    if (cmd.check) begin
      if (stat.overflow) begin
        cur_r <= cco_pkg::CNT_MAX;
        sat_r <= 1'b1;
      end else begin
        cur_r <= prod_r[CW-1:0];
        j_r   <= j_r + 1'b1;
      end
    end
    if (cmd.finish) begin
      count_out_r  <= cur_r;
      offset_out_r <= end_nxt;
      total_out_r  <= last_r;
      ovf_out_r    <= sat_r || off_sat;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.combo_count = count_out_r;
  assign out_chan.end_offset  = offset_out_r;
  assign out_chan.is_total    = total_out_r;
  assign out_chan.overflowed  = ovf_out_r;

  // division by j is exact: nothing left over
  a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.check |-> rem_r == '0)
    else $error("non-zero remainder after binomial step");

  // a finished word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_chan.ready))
    else $error("output word overwritten");

  a_offset_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> offset_out_r >= count_out_r)
    else $error("end offset below count");

  a_divisor_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> j_r >= JW'(2))
    else $error("divisor below two");

endmodule

>>> sv/combination_count_offsets_top.sv
// Combination count and running offset per list: a multiply / exact-divide
// iteration of t - 1 steps, t = min(k, size - k). One list is worked at a
// time; a count of 0, 1 or the size is settled without iterating. Each
// step is a two-pass multiply, the divider that retires one quotient bit
// per cycle over the 97-bit product, and a check. A saturating count ends
// the iteration early. The output word sits in its own register, so the
// next list is taken while a word waits.
// Depends on cco_pkg, cco_if, cco_ctrl and cco_dp.
module combination_count_offsets_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cco_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cco_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  cco_in_if.sink                          in_chan,
  cco_out_if.source                       out_chan
);

  cco_pkg::cco_cmd_t  cmd;
  cco_pkg::cco_stat_t stat;
  logic               in_ready;

  assign in_chan.ready = in_ready;

  cco_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cco_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .list_start (in_chan.list_start),
    .list_stop  (in_chan.list_stop),
    .last_list  (in_chan.last_list),
    .cmd        (cmd),
    .stat       (stat),
    .out_chan   (out_chan)
  );

endmodule
